// ----- src/l1_distance_conv_output_defines.svh -----
// Assertion macros shared by the checker of the L1-distance convolution block.
// Depends on nothing; the including module must have i_clk and i_rst_n in scope.
`ifndef L1_DISTANCE_CONV_OUTPUT_DEFINES_SVH
`define L1_DISTANCE_CONV_OUTPUT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define L1DC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("l1dc check failed");

// Consequent must hold in the cycle after the antecedent.
`define L1DC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("l1dc check failed");

`endif

// ----- src/l1dc_pkg.sv -----
// Package of the L1-distance convolution block: sizes, codes and shared types.
// Used by every module of the block; depends on nothing.
package l1dc_pkg;

    localparam int MAX_HEIGHT   = 32;
    localparam int MAX_WIDTH    = 32;
    localparam int IN_CHANNELS  = 8;
    localparam int OUT_CHANNELS = 16;
    localparam int MAX_KERNEL   = 7;
    localparam int DATA_BITS    = 16;

    // Fixed field widths of the ports.
    localparam int DIST_BITS    = 26;
    localparam int KSZ_BITS     = 3;
    localparam int IMG_BITS     = 6;
    localparam int CFG_BITS     = 6;
    localparam int CFG_IDX_BITS = 3;
    localparam int CRD_BITS     = 11;

    localparam int FEAT_DEPTH = IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int KERN_DEPTH = OUT_CHANNELS * IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int FEAT_ABITS = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int KERN_ABITS = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
    localparam int CH_BITS    = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
    localparam int KCH_STRIDE = MAX_KERNEL * MAX_KERNEL;
    localparam int KCO_STRIDE = IN_CHANNELS * KCH_STRIDE;

    localparam logic [1:0] OP_WR_ACT  = 2'd0;
    localparam logic [1:0] OP_WR_WGT  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_KW = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_KH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SH = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SV = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PH = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PV = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_IH = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_IW = 3'd7;

    typedef logic [DATA_BITS-1:0]       t_word;
    typedef logic [FEAT_ABITS-1:0]      t_faddr;
    typedef logic [KERN_ABITS-1:0]      t_kaddr;
    typedef logic signed [CRD_BITS-1:0] t_crd;
    typedef logic [KSZ_BITS-1:0]        t_ksz;
    typedef logic [IMG_BITS-1:0]        t_img;

    // One kernel tap issued to the arithmetic unit.
    typedef struct packed {
        logic vld;
        logic in_img;
    } t_tap;

    // Everything the tap sequencer needs for one output element.
    typedef struct packed {
        t_crd   bh;
        t_crd   bw;
        t_kaddr kbase;
        t_ksz   kw;
        t_ksz   kh;
        t_img   ih;
        t_img   iw;
    } t_job;

    // Store write request.
    typedef struct packed {
        logic   feat_we;
        logic   kern_we;
        t_faddr feat_addr;
        t_kaddr kern_addr;
        t_word  word;
    } t_wr;

endpackage

// ----- src/l1dc_store.sv -----
// Feature and kernel stores of the L1-distance convolution block.
// Each is one write port and one registered read port; depends on l1dc_pkg.
module l1dc_store
    import l1dc_pkg::*;
(
    input  logic   i_clk,
    input  t_wr    i_wr,
    input  t_faddr i_feat_raddr,
    input  t_kaddr i_kern_raddr,
    output t_word  o_act,
    output t_word  o_wgt
);

    t_word r_feat_mem [FEAT_DEPTH];
    t_word r_kern_mem [KERN_DEPTH];
    t_word r_act;
    t_word r_wgt;

    always_ff @(posedge i_clk) begin
        if (i_wr.feat_we) begin
            r_feat_mem[i_wr.feat_addr] <= i_wr.word;
        end
        r_act <= r_feat_mem[i_feat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.kern_we) begin
            r_kern_mem[i_wr.kern_addr] <= i_wr.word;
        end
        r_wgt <= r_kern_mem[i_kern_raddr];
    end

    assign o_act = r_act;
    assign o_wgt = r_wgt;

endmodule

// ----- src/l1dc_seq.sv -----
// Tap sequencer: walks input channels, kernel rows and kernel columns, one tap
// per cycle, and forms the store addresses and the padding flag. Uses l1dc_pkg.
module l1dc_seq
    import l1dc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_job   i_job,
    output t_tap   o_tap,
    output t_faddr o_faddr,
    output t_kaddr o_kaddr,
    output logic   o_busy
);

    logic               r_run,  n_run;
    t_job               r_job;
    logic [CH_BITS-1:0] r_ch,   n_ch;
    t_ksz               r_y,    n_y;
    t_ksz               r_x,    n_x;
    t_kaddr             r_krow, n_krow;
    t_kaddr             r_kch,  n_kch;

    t_crd h;
    t_crd w;
    logic in_img;
    logic last_x;
    logic last_y;
    logic last_ch;

    always_comb begin
        h = r_job.bh + $signed({{(CRD_BITS-KSZ_BITS){1'b0}}, r_y});
        w = r_job.bw + $signed({{(CRD_BITS-KSZ_BITS){1'b0}}, r_x});
        in_img = !h[CRD_BITS-1] && !w[CRD_BITS-1]
              && (h < $signed({{(CRD_BITS-IMG_BITS){1'b0}}, r_job.ih}))
              && (w < $signed({{(CRD_BITS-IMG_BITS){1'b0}}, r_job.iw}));
        last_x  = (r_x == r_job.kw - 1'b1);
        last_y  = (r_y == r_job.kh - 1'b1);
        last_ch = (r_ch == CH_BITS'(IN_CHANNELS - 1));
    end

    always_comb begin
        n_run  = r_run;
        n_ch   = r_ch;
        n_y    = r_y;
        n_x    = r_x;
        n_krow = r_krow;
        n_kch  = r_kch;
        if (i_start) begin
            // A kernel with no rows or no columns has no taps at all.
            n_run  = (i_job.kw != '0) && (i_job.kh != '0);
            n_ch   = '0;
            n_y    = '0;
            n_x    = '0;
            n_krow = i_job.kbase;
            n_kch  = i_job.kbase;
        end else if (r_run) begin
            if (!last_x) begin
                n_x = r_x + 1'b1;
            end else begin
                n_x = '0;
                if (!last_y) begin
                    n_y    = r_y + 1'b1;
                    n_krow = r_krow + KERN_ABITS'(MAX_KERNEL);
                end else begin
                    n_y    = '0;
                    n_ch   = r_ch + 1'b1;
                    n_krow = r_kch + KERN_ABITS'(KCH_STRIDE);
                    n_kch  = r_kch + KERN_ABITS'(KCH_STRIDE);
                    if (last_ch) begin
                        n_run = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_job <= i_job;
        end
        r_ch   <= n_ch;
        r_y    <= n_y;
        r_x    <= n_x;
        r_krow <= n_krow;
        r_kch  <= n_kch;
    end

    assign o_tap.vld    = r_run;
    assign o_tap.in_img = in_img;
    assign o_faddr = FEAT_ABITS'((int'(r_ch) * MAX_HEIGHT + int'(h)) * MAX_WIDTH + int'(w));
    assign o_kaddr = r_krow + KERN_ABITS'(r_x);
    assign o_busy  = r_run;

endmodule

// ----- src/l1dc_absacc.sv -----
// Shared absolute-difference and accumulate unit: one tap per cycle, two
// register stages behind the store read. Uses l1dc_pkg.
module l1dc_absacc
    import l1dc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr,
    input  t_tap                 i_tap,
    input  t_word                i_act,
    input  t_word                i_wgt,
    output logic [DIST_BITS-1:0] o_acc,
    output logic                 o_busy
);

    logic                 r_p1_vld;
    logic                 r_p1_in;
    logic                 r_p2_vld;
    logic [DATA_BITS:0]   r_mag;
    logic [DIST_BITS-1:0] r_acc;

    logic signed [DATA_BITS:0] act_ext;
    logic signed [DATA_BITS:0] wgt_ext;
    logic signed [DATA_BITS:0] diff;
    logic        [DATA_BITS:0] n_mag;

    // A padded tap compares the weight against zero.
    always_comb begin
        act_ext = r_p1_in ? $signed({i_act[DATA_BITS-1], i_act}) : '0;
        wgt_ext = $signed({i_wgt[DATA_BITS-1], i_wgt});
        diff    = act_ext - wgt_ext;
        n_mag   = diff[DATA_BITS] ? $unsigned(-diff) : $unsigned(diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_tap.vld;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_in <= i_tap.in_img;
        r_mag   <= n_mag;
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc - DIST_BITS'(r_mag);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_p1_vld || r_p2_vld;

endmodule

// ----- src/l1_distance_conv_output.sv -----
// L1-distance (adder-layer) convolution, one output element per compute item.
// A write item (activation or weight) returns its status in the next cycle;
// a compute item for a missing output channel and an item with the unused
// opcode answer the same way. For a compute item the sequencer feeds one
// kernel tap per cycle from the feature and kernel stores into a single
// absolute-difference and accumulate unit; the store read register, the
// magnitude register and the accumulator lie between a tap and its sum,
// and the output register holds the result. A kernel with no rows or no
// columns answers with zero distance and issues no taps. The block takes a
// new item once the previous result has been produced and the output
// register is free or being emptied; configuration writes are taken at any
// time but are meant for idle periods. Store entries that were never
// written read back as unknown data.
module l1_distance_conv_output
    import l1dc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // out_channel[3:0], in_channel[6:4], row[12:7], column[18:13],
    // tap_row[21:19], tap_column[24:22], data_value[40:25], zero fill above
    input  logic [47:0]             i_s_tdata,
    // opcode[1:0]
    input  logic [1:0]              i_s_tuser,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // distance[25:0], zero fill above
    output logic [31:0]             o_m_tdata,
    // status[0]
    output logic [0:0]              o_m_tuser,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic r_state, n_state;

    t_ksz r_kw, r_kh, r_sh, r_sv, r_ph, r_pv;
    t_img r_ih, r_iw;

    logic                 r_out_vld, n_out_vld;
    logic [DIST_BITS-1:0] r_dist,    n_dist;
    logic                 r_status,  n_status;
    logic                 out_load;

    logic [3:0]  f_co;
    logic [2:0]  f_ci;
    logic [5:0]  f_row;
    logic [5:0]  f_col;
    logic [2:0]  f_tr;
    logic [2:0]  f_tc;
    logic [15:0] f_data;

    logic   accept;
    logic   act_ok, wgt_ok, co_ok;
    logic   start;
    t_job   job;
    t_wr    wr;
    t_tap   tap;
    t_faddr feat_raddr;
    t_kaddr kern_raddr;
    t_word  act, wgt;
    logic   seq_busy, acc_busy;
    logic [DIST_BITS-1:0] acc;

    assign f_co   = i_s_tdata[3:0];
    assign f_ci   = i_s_tdata[6:4];
    assign f_row  = i_s_tdata[12:7];
    assign f_col  = i_s_tdata[18:13];
    assign f_tr   = i_s_tdata[21:19];
    assign f_tc   = i_s_tdata[24:22];
    assign f_data = i_s_tdata[40:25];

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_vld || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        act_ok = (int'(f_ci) < IN_CHANNELS) && (int'(f_row) < MAX_HEIGHT)
              && (int'(f_col) < MAX_WIDTH);
        co_ok  = (int'(f_co) < OUT_CHANNELS);
        wgt_ok = co_ok && (int'(f_ci) < IN_CHANNELS)
              && (int'(f_tr) < MAX_KERNEL) && (int'(f_tc) < MAX_KERNEL);
    end

    always_comb begin
        wr.feat_we   = accept && (i_s_tuser == OP_WR_ACT) && act_ok;
        wr.kern_we   = accept && (i_s_tuser == OP_WR_WGT) && wgt_ok;
        wr.feat_addr = FEAT_ABITS'((int'(f_ci) * MAX_HEIGHT + int'(f_row)) * MAX_WIDTH
                     + int'(f_col));
        wr.kern_addr = KERN_ABITS'(((int'(f_co) * IN_CHANNELS + int'(f_ci)) * MAX_KERNEL
                     + int'(f_tr)) * MAX_KERNEL + int'(f_tc));
        wr.word      = t_word'(f_data);
    end

    // Window origin and clamped sizes for a compute item.
    always_comb begin
        job.bh    = CRD_BITS'(int'(f_row) * int'(r_sv) - int'(r_pv));
        job.bw    = CRD_BITS'(int'(f_col) * int'(r_sh) - int'(r_ph));
        job.kbase = KERN_ABITS'(int'(f_co) * KCO_STRIDE);
        job.kw    = (int'(r_kw) > MAX_KERNEL) ? KSZ_BITS'(MAX_KERNEL) : r_kw;
        job.kh    = (int'(r_kh) > MAX_KERNEL) ? KSZ_BITS'(MAX_KERNEL) : r_kh;
        job.ih    = (int'(r_ih) > MAX_HEIGHT) ? IMG_BITS'(MAX_HEIGHT) : r_ih;
        job.iw    = (int'(r_iw) > MAX_WIDTH)  ? IMG_BITS'(MAX_WIDTH)  : r_iw;
    end

    assign start = accept && (i_s_tuser == OP_COMPUTE) && co_ok;

    l1dc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_job   (job),
        .o_tap   (tap),
        .o_faddr (feat_raddr),
        .o_kaddr (kern_raddr),
        .o_busy  (seq_busy)
    );

    l1dc_store u_store (
        .i_clk        (i_clk),
        .i_wr         (wr),
        .i_feat_raddr (feat_raddr),
        .i_kern_raddr (kern_raddr),
        .o_act        (act),
        .o_wgt        (wgt)
    );

    l1dc_absacc u_absacc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (start),
        .i_tap   (tap),
        .i_act   (act),
        .i_wgt   (wgt),
        .o_acc   (acc),
        .o_busy  (acc_busy)
    );

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        n_dist   = r_dist;
        n_status = r_status;
        case (r_state)
            ST_IDLE: begin
                if (accept && !start) begin
                    // Writes, bad channels and unknown opcodes answer at once.
                    out_load = 1'b1;
                    n_dist   = '0;
                    case (i_s_tuser)
                        OP_WR_ACT: n_status = !act_ok;
                        OP_WR_WGT: n_status = !wgt_ok;
                        default:   n_status = 1'b1;
                    endcase
                end else if (start) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (!seq_busy && !acc_busy) begin
                    out_load = 1'b1;
                    n_dist   = acc;
                    n_status = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_vld = out_load || (r_out_vld && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_kw      <= 3'd3;
            r_kh      <= 3'd3;
            r_sh      <= 3'd1;
            r_sv      <= 3'd1;
            r_ph      <= 3'd1;
            r_pv      <= 3'd1;
            r_ih      <= 6'd32;
            r_iw      <= 6'd32;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KW:  r_kw <= i_cfg_data[KSZ_BITS-1:0];
                    REG_KH:  r_kh <= i_cfg_data[KSZ_BITS-1:0];
                    REG_SH:  r_sh <= i_cfg_data[KSZ_BITS-1:0];
                    REG_SV:  r_sv <= i_cfg_data[KSZ_BITS-1:0];
                    REG_PH:  r_ph <= i_cfg_data[KSZ_BITS-1:0];
                    REG_PV:  r_pv <= i_cfg_data[KSZ_BITS-1:0];
                    REG_IH:  r_ih <= i_cfg_data[IMG_BITS-1:0];
                    REG_IW:  r_iw <= i_cfg_data[IMG_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_dist   <= n_dist;
            r_status <= n_status;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(32-DIST_BITS){1'b0}}, r_dist};
    assign o_m_tuser  = r_status;

endmodule

// ----- src/l1dc_checker.sv -----
// Port-level checker of the L1-distance convolution block, bound to the top.
// Depends on l1dc_pkg and on the macros in l1_distance_conv_output_defines.svh.
`include "l1_distance_conv_output_defines.svh"

module l1dc_port_checker
    import l1dc_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_s_tvalid,
    input logic                    o_s_tready,
    input logic [47:0]             i_s_tdata,
    input logic [1:0]              i_s_tuser,
    input logic                    o_m_tvalid,
    input logic                    i_m_tready,
    input logic [31:0]             o_m_tdata,
    input logic [0:0]              o_m_tuser,
    input logic                    i_cfg_we,
    input logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input logic [CFG_BITS-1:0]     i_cfg_data
);

    logic res_stall;
    logic quick_item;
    logic zero_res;
    logic dist_zero;

    assign res_stall  = o_m_tvalid && !i_m_tready;
    assign quick_item = i_s_tvalid && o_s_tready && (i_s_tuser != OP_COMPUTE);
    assign zero_res   = o_m_tvalid && (o_m_tdata == 32'd0);
    assign dist_zero  = (o_m_tdata[DIST_BITS-1:0] == '0);

    // A stalled result blocks new items, so no result can be overwritten.
    `L1DC_ASSERT_NOW(a_no_accept_on_stall, res_stall, !o_s_tready)

    // An item that is not a compute answers in the very next cycle with zero distance.
    `L1DC_ASSERT_NEXT(a_write_answers_next, quick_item, zero_res)

    // An ignored item never carries a distance.
    `L1DC_ASSERT_NOW(a_status_zero_dist, o_m_tvalid && o_m_tuser[0], dist_zero)

    // The distance is a sum of negated magnitudes.
    `L1DC_ASSERT_NOW(a_dist_not_positive, o_m_tvalid, o_m_tdata[DIST_BITS-1] || dist_zero)

    `L1DC_ASSERT_NEXT(a_result_held, res_stall, o_m_tvalid && $stable({o_m_tdata, o_m_tuser}))

endmodule

bind l1_distance_conv_output l1dc_port_checker u_l1dc_checker (.*);
